/* sv/erot_pkg.sv */
package erot_pkg;

  // Fixed field widths of the vector and coefficient formats.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COEF_W = 18;
  localparam int unsigned PROD_W = DATA_W + COEF_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned IDX_W  = 3;

  // Fraction bits of both the vector and the coefficient formats.
  localparam int unsigned FRAC_BITS = 16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Reset values of the coefficient registers (Q1.16).
  localparam coef_t COEF_ONE  = 18'sh10000;
  localparam coef_t COEF_ZERO = 18'sh00000;

  // Coefficient register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_COS_X = 3'd0,
    CFG_SIN_X = 3'd1,
    CFG_COS_Y = 3'd2,
    CFG_SIN_Y = 3'd3,
    CFG_COS_Z = 3'd4,
    CFG_SIN_Z = 3'd5
  } cfg_idx_e;

endpackage

/* sv/erot_if.sv */
// Request channel carrying the vector to be rotated.
interface erot_in_if;
  import erot_pkg::*;

  logic  valid;
  logic  ready;
  data_t in_x;
  data_t in_y;
  data_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// Result channel carrying the rotated vector.
interface erot_out_if;
  import erot_pkg::*;

  logic  valid;
  logic  ready;
  data_t out_x;
  data_t out_y;
  data_t out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

/* sv/euler_xyz_vector_rotator_unit.sv */
// Rotates one signed Q15.16 vector per request about X, then Y, then Z, using six
// Q1.16 sine and cosine registers written through the configuration port. The datapath
// is a six-stage pipeline (a multiply stage and a round-and-saturate stage per axis), so
// it takes one request every cycle unless a result waits untaken at the output. The
// whole pipeline then holds, and the input is not ready. Each component is a sum or
// difference of two products, rounded half up, shifted right by FRAC_BITS and
// saturated to 32 bits before the next axis uses it. The user must see that the
// coefficient registers are changed only while no request is in flight; the block
// itself does not enforce this. A write to an index above five is ignored.
module euler_xyz_vector_rotator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  erot_in_if.sink                    in_i,
  erot_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [erot_pkg::IDX_W-1:0] cfg_idx_i,
  input  erot_pkg::coef_t            cfg_data_i
);
  import erot_pkg::*;

  localparam int unsigned STAGES = 6;

  // Round half up, shift and saturate a sum or difference of two products.
  function automatic data_t rnd_sat(input prod_t a, input prod_t b, input logic sub);
    sum_t sum;
    sum_t sh;
    logic fits;
    sum = sub ? (SUM_W'(a) - SUM_W'(b)) : (SUM_W'(a) + SUM_W'(b));
    sum = sum + (sum_t'(1) <<< (FRAC_BITS - 1));
    sh  = sum >>> FRAC_BITS;
    fits = (&sh[SUM_W-1:DATA_W-1]) || (~|sh[SUM_W-1:DATA_W-1]);
    if (fits) begin
      rnd_sat = sh[DATA_W-1:0];
    end else if (sh[SUM_W-1]) begin
      rnd_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic prod_t mul(input data_t d, input coef_t c);
    mul = prod_t'(d) * prod_t'(c);
  endfunction

  coef_t cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;

  logic [STAGES-1:0] vld_q;
  logic              advance;

  prod_t s0_prod_q [4];
  data_t s0_x_q;
  data_t s1_x_q, s1_y_q, s1_z_q;
  prod_t s2_prod_q [4];
  data_t s2_y_q;
  data_t s3_x_q, s3_y_q, s3_z_q;
  prod_t s4_prod_q [4];
  data_t s4_z_q;
  data_t s5_x_q, s5_y_q, s5_z_q;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_x_q <= COEF_ONE;
      sin_x_q <= COEF_ZERO;
      cos_y_q <= COEF_ONE;
      sin_y_q <= COEF_ZERO;
      cos_z_q <= COEF_ONE;
      sin_z_q <= COEF_ZERO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COS_X: cos_x_q <= cfg_data_i;
        CFG_SIN_X: sin_x_q <= cfg_data_i;
        CFG_COS_Y: cos_y_q <= cfg_data_i;
        CFG_SIN_Y: sin_y_q <= cfg_data_i;
        CFG_COS_Z: cos_z_q <= cfg_data_i;
        CFG_SIN_Z: sin_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole unless the output holds an untaken result.
  assign advance    = out_o.ready || !vld_q[STAGES-1];
  assign in_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[STAGES-2:0], in_i.valid};
    end
  end

  // Datapath: products, then rounded sums, once per axis.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      // About X: y' = y*c - z*s, z' = y*s + z*c.
      s0_prod_q[0] <= mul(in_i.in_y, cos_x_q);
      s0_prod_q[1] <= mul(in_i.in_z, sin_x_q);
      s0_prod_q[2] <= mul(in_i.in_y, sin_x_q);
      s0_prod_q[3] <= mul(in_i.in_z, cos_x_q);
      s0_x_q       <= in_i.in_x;

      s1_x_q <= s0_x_q;
      s1_y_q <= rnd_sat(s0_prod_q[0], s0_prod_q[1], 1'b1);
      s1_z_q <= rnd_sat(s0_prod_q[2], s0_prod_q[3], 1'b0);

      // About Y: x' = x*c + z*s, z' = z*c - x*s.
      s2_prod_q[0] <= mul(s1_x_q, cos_y_q);
      s2_prod_q[1] <= mul(s1_z_q, sin_y_q);
      s2_prod_q[2] <= mul(s1_z_q, cos_y_q);
      s2_prod_q[3] <= mul(s1_x_q, sin_y_q);
      s2_y_q       <= s1_y_q;

      s3_x_q <= rnd_sat(s2_prod_q[0], s2_prod_q[1], 1'b0);
      s3_y_q <= s2_y_q;
      s3_z_q <= rnd_sat(s2_prod_q[2], s2_prod_q[3], 1'b1);

      // About Z: x' = x*c - y*s, y' = x*s + y*c.
      s4_prod_q[0] <= mul(s3_x_q, cos_z_q);
      s4_prod_q[1] <= mul(s3_y_q, sin_z_q);
      s4_prod_q[2] <= mul(s3_x_q, sin_z_q);
      s4_prod_q[3] <= mul(s3_y_q, cos_z_q);
      s4_z_q       <= s3_z_q;

      s5_x_q <= rnd_sat(s4_prod_q[0], s4_prod_q[1], 1'b1);
      s5_y_q <= rnd_sat(s4_prod_q[2], s4_prod_q[3], 1'b0);
      s5_z_q <= s4_z_q;
    end
  end

  assign out_o.valid = vld_q[STAGES-1];
  assign out_o.out_x = s5_x_q;
  assign out_o.out_y = s5_y_q;
  assign out_o.out_z = s5_z_q;

endmodule

/* sv/erot_checker.sv */
module erot_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [erot_pkg::DATA_W-1:0] out_x_i,
  input logic [erot_pkg::DATA_W-1:0] out_y_i,
  input logic [erot_pkg::DATA_W-1:0] out_z_i
);
  import erot_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output result withdrawn before it was taken");

  // A result that is not taken keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i))
    else $error("output result changed while stalled");

  // The input is ready exactly when the output does not hold a waiting result.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (out_ready_i || !out_valid_i))
    else $error("input ready does not follow the output stall");

  // The handshake outputs of the block are always known once out of reset.
  a_known_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_i, out_valid_i}))
    else $error("handshake output of the block is unknown");

endmodule

bind euler_xyz_vector_rotator_unit erot_checker u_erot_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_y_i     (out_o.out_y),
  .out_z_i     (out_o.out_z)
);

/* sim/euler_xyz_vector_rotator_unit_tb.sv */
module euler_xyz_vector_rotator_unit_tb;
  import erot_pkg::*;

  localparam int          PIPE_DEPTH = 6;
  localparam int          BLOCKS     = 5;
  localparam int          BLOCK_LEN  = 31;

  // Indexes above the last coefficient register, which the block must ignore.
  localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam data_t DATA_MAX = 32'sh7fffffff;
  localparam data_t DATA_MIN = 32'sh80000000;
  localparam coef_t COEF_MAX = 18'sh1ffff;
  localparam coef_t COEF_MIN = 18'sh20000;
  localparam coef_t COEF_HALF = 18'sh08000;
  localparam longint SAT_HI = (longint'(1) <<< 31) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< 31);

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  coef_t cfg_data;

  erot_in_if  vec_in ();
  erot_out_if vec_out ();

  // Shadow of the coefficient registers and the set being prepared for the next load.
  coef_t coef_shadow [6];
  coef_t staged [6];
  bit    spare_toggle = 1'b0;

  vec_t pending_rotations [$];
  int   mismatch_count = 0;
  int   send_gap_pct   = 0;
  int   recv_stall_pct = 0;
  int   stall_request  = 0;

  always #6 clk = ~clk;

  euler_xyz_vector_rotator_unit i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (vec_in),
    .out_o     (vec_out),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Round half up, floor shift and clamp to the signed 32-bit range.
  function automatic data_t round_clamp(longint sum);
    longint q;
    q = (sum + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return data_t'(q);
  endfunction

  function automatic data_t mix_pair(longint a, longint ka, longint b, longint kb);
    return round_clamp(a * ka + b * kb);
  endfunction

  // Expected rotation about X, then Y, then Z with the current coefficients.
  function automatic vec_t rotate_xyz(data_t in_x, data_t in_y, data_t in_z);
    longint cx, sx, cy, sy, cz, sz;
    data_t  x, y, z, nx, ny, nz;
    vec_t   r;
    cx = coef_shadow[CFG_COS_X];
    sx = coef_shadow[CFG_SIN_X];
    cy = coef_shadow[CFG_COS_Y];
    sy = coef_shadow[CFG_SIN_Y];
    cz = coef_shadow[CFG_COS_Z];
    sz = coef_shadow[CFG_SIN_Z];
    x = in_x;
    y = in_y;
    z = in_z;
    ny = mix_pair(y, cx, z, -sx);
    nz = mix_pair(y, sx, z, cx);
    y = ny;
    z = nz;
    nx = mix_pair(x, cy, z, sy);
    nz = mix_pair(z, cy, x, -sy);
    x = nx;
    z = nz;
    nx = mix_pair(x, cz, y, -sz);
    ny = mix_pair(x, sz, y, cz);
    r.x = nx;
    r.y = ny;
    r.z = z;
    return r;
  endfunction

  // Full-range words and small magnitudes in equal share, some corner values.
  function automatic data_t random_component();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return data_t'($urandom);
    end else if (pick < 8) begin
      return data_t'($urandom_range(0, 32'h000fffff)) - data_t'(32'h00080000);
    end
    case ($urandom_range(0, 4))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return data_t'(1);
      3: return data_t'(-1);
      default: return data_t'(0);
    endcase
  endfunction

  function automatic coef_t extreme_coef();
    case ($urandom_range(0, 4))
      0: return COEF_ONE;
      1: return -COEF_ONE;
      2: return COEF_MAX;
      3: return COEF_MIN;
      default: return COEF_ZERO;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic set_idling(input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic stage_axis(input int axis, input coef_t c, input coef_t s);
    staged[2 * axis]     = c;
    staged[2 * axis + 1] = s;
  endtask

  task automatic stage_angle(input int axis);
    real ang;
    ang = $urandom_range(0, 62831) / 10000.0;
    stage_axis(axis, coef_t'(int'($cos(ang) * 65536.0)), coef_t'(int'($sin(ang) * 65536.0)));
  endtask

  // Write all six coefficients, then one ignored index with random data.
  task automatic load_staged();
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= IDX_W'(i);
      cfg_data <= staged[i];
      coef_shadow[i] = staged[i];
      @(posedge clk);
    end
    cfg_idx  <= spare_toggle ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_data <= coef_t'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    spare_toggle = !spare_toggle;
  endtask

  // Offer one request and wait until the block takes it.
  task automatic send_vector(input data_t x, input data_t y, input data_t z);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      vec_in.valid <= 1'b0;
      @(posedge clk);
    end
    vec_in.valid <= 1'b1;
    vec_in.in_x  <= x;
    vec_in.in_y  <= y;
    vec_in.in_z  <= z;
    @(posedge clk);
    while (vec_in.ready !== 1'b1) begin
      @(posedge clk);
    end
    pending_rotations.push_back(rotate_xyz(x, y, z));
  endtask

  // Leave the input idle until every expected result has been delivered.
  task automatic drain();
    vec_in.valid <= 1'b0;
    while (pending_rotations.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic send_corner_vectors();
    send_vector(data_t'(0), data_t'(0), data_t'(0));
    send_vector(DATA_MAX, DATA_MAX, DATA_MAX);
    send_vector(DATA_MIN, DATA_MIN, DATA_MIN);
    send_vector(DATA_MAX, DATA_MIN, data_t'(0));
    send_vector(data_t'(1), data_t'(-1), data_t'(1));
    send_vector(data_t'(-1), data_t'(0), data_t'(0));
    send_vector(data_t'(32'h00010000), data_t'(0), data_t'(0));
    send_vector(data_t'(0), data_t'(32'h00010000), data_t'(-32'sh00010000));
  endtask

  // Corner vectors at the reset coefficients, at one half (rounding of
  // exact halves) and at the widest coefficients (saturation).
  task automatic test_directed_extremes();
    set_idling(37, 59);
    send_corner_vectors();
    drain();
    for (int axis = 0; axis < 3; axis++) begin
      stage_axis(axis, COEF_HALF, COEF_HALF);
    end
    load_staged();
    send_corner_vectors();
    drain();
    stage_axis(0, COEF_MAX, COEF_MIN);
    stage_axis(1, COEF_MIN, COEF_MAX);
    stage_axis(2, COEF_MAX, COEF_MIN);
    load_staged();
    send_corner_vectors();
    drain();
  endtask

  // Blocks of random vectors, each under a fresh set of coefficients.
  task automatic test_random_rotations(input int gap_pct, input int stall_pct);
    set_idling(gap_pct, stall_pct);
    for (int blk = 0; blk < BLOCKS; blk++) begin
      for (int axis = 0; axis < 3; axis++) begin
        case (blk)
          1: stage_axis(axis, coef_t'($urandom), coef_t'($urandom));
          2: stage_axis(axis, extreme_coef(), extreme_coef());
          3: begin
            if ($urandom_range(0, 1) == 0) begin
              stage_axis(axis, COEF_ONE, COEF_ZERO);
            end else begin
              stage_angle(axis);
            end
          end
          default: stage_angle(axis);
        endcase
      end
      load_staged();
      for (int i = 0; i < BLOCK_LEN; i++) begin
        send_vector(random_component(), random_component(), random_component());
      end
      drain();
    end
  endtask

  // The receiver holds off while requests keep coming, so the pipeline fills.
  task automatic test_backpressure();
    set_idling(0, 20);
    for (int axis = 0; axis < 3; axis++) begin
      stage_angle(axis);
    end
    load_staged();
    stall_request = 150;
    repeat (60) begin
      send_vector(random_component(), random_component(), random_component());
    end
    drain();
  endtask

  // Result side: check each delivered vector and choose the next ready level.
  initial begin : result_checker
    vec_t want;
    int   hold_left;
    hold_left = 0;
    vec_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (vec_out.valid === 1'b1 && vec_out.ready === 1'b1) begin
        if (pending_rotations.size() == 0) begin
          report_mismatch("result with nothing pending", $signed(vec_out.out_x), 0);
        end else begin
          want = pending_rotations.pop_front();
          if (vec_out.out_x !== want.x) begin
            report_mismatch("out_x", $signed(vec_out.out_x), $signed(want.x));
          end
          if (vec_out.out_y !== want.y) begin
            report_mismatch("out_y", $signed(vec_out.out_y), $signed(want.y));
          end
          if (vec_out.out_z !== want.z) begin
            report_mismatch("out_z", $signed(vec_out.out_z), $signed(want.z));
          end
        end
      end
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        vec_out.ready <= 1'b0;
      end else begin
        vec_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_COS_X;
    cfg_data     = COEF_ZERO;
    vec_in.valid = 1'b0;
    vec_in.in_x  = '0;
    vec_in.in_y  = '0;
    vec_in.in_z  = '0;
    coef_shadow[CFG_COS_X] = COEF_ONE;
    coef_shadow[CFG_SIN_X] = COEF_ZERO;
    coef_shadow[CFG_COS_Y] = COEF_ONE;
    coef_shadow[CFG_SIN_Y] = COEF_ZERO;
    coef_shadow[CFG_COS_Z] = COEF_ONE;
    coef_shadow[CFG_SIN_Z] = COEF_ZERO;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_random_rotations(37, 59);
    test_random_rotations(59, 37);
    test_random_rotations(0, 0);
    test_backpressure();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (pending_rotations.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_rotations.size());
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #(12 * 300000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
